FILE: rtl/dlps_pkg.sv
`timescale 1ns / 1ps

package dlps_pkg;

  localparam int RUN_FIELDS_DEF = 8;
  localparam int PAT_W = 32;
  localparam int PAT_NIBBLES = PAT_W / 4;
  localparam int SLOT_W = 8;
  localparam int BLINK_W = 8;
  localparam int DELAY_W = 16;
  localparam int HOLD_W = 8;
  localparam logic [HOLD_W-1:0] HOLD_RESET = 8'd10;
  localparam logic [BLINK_W-1:0] BLINK_STEADY = 8'hff;
  localparam logic [PAT_W-1:0] BLINK_MASK = 32'h12;
  localparam logic [SLOT_W-1:0] BLINK_PERIOD = 8'd3;
  localparam logic [SLOT_W-1:0] STEADY_PERIOD = 8'd1;

  typedef enum logic [2:0] {
    OP_TICK    = 3'd0,
    OP_PATTERN = 3'd1,
    OP_BLINKS  = 3'd2,
    OP_STEADY  = 3'd3,
    OP_PAUSE   = 3'd4,
    OP_DELAY   = 3'd5
  } op_e;

  typedef enum logic [1:0] {
    KIND_ZERO  = 2'd0,
    KIND_ONE   = 2'd1,
    KIND_PAT   = 2'd2,
    KIND_BLINK = 2'd3
  } kind_e;

  typedef struct packed {
    logic [2:0]         opcode;
    logic [PAT_W-1:0]   primary_pattern;
    logic [PAT_W-1:0]   secondary_pattern;
    logic [BLINK_W-1:0] primary_blinks;
    logic [BLINK_W-1:0] secondary_blinks;
    logic               flag;
    logic [DELAY_W-1:0] delay_slots;
  } dlps_in_t;

  typedef struct packed {
    logic primary_on;
    logic secondary_on;
    logic delaying;
    logic paused_now;
  } dlps_out_t;

endpackage

FILE: rtl/dual_led_pattern_sequencer_top.sv
`timescale 1ns / 1ps

// Channel   Direction  Handshake                 Word
// input     in         in_valid_i / in_stall_o   in_word_i   (dlps_in_t)
// output    out        out_valid_o / out_stall_i out_word_o  (dlps_out_t)
// config    in         cfg_we_i                  cfg_wdata_i (holdoff slots)
//
// One word is taken at a time. A non-pattern event is handled in steps: the event is
// applied, the blink state is evaluated, the bit-serial slot modulo and the nibble
// walker run, and then the result is registered.
// While paused the modulo and the walker are skipped;
// a pattern event adds the nibble-serial compare and period sum.
// Reset is asynchronous and active low and needs no clearing pass.
// A stalled result holds in the output register; the next word is taken meanwhile.

module dual_led_pattern_sequencer_top #(
  parameter int RUN_FIELDS = dlps_pkg::RUN_FIELDS_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  dlps_pkg::dlps_in_t  in_word_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output dlps_pkg::dlps_out_t out_word_o,
  input  logic                cfg_we_i,
  input  logic [7:0]          cfg_wdata_i
);

  import dlps_pkg::*;

  localparam int IdxW = $clog2(PAT_NIBBLES);
  localparam int CntW = $clog2(PAT_NIBBLES + 1);
  localparam int Fields = (RUN_FIELDS < PAT_NIBBLES) ? RUN_FIELDS : PAT_NIBBLES;
  localparam logic [CntW-1:0] FieldsLim = CntW'(Fields);
  localparam logic [IdxW-1:0] ScanLast = IdxW'(PAT_NIBBLES - 1);
  localparam logic [IdxW-1:0] DivLast = IdxW'(SLOT_W - 1);

  typedef enum logic [6:0] {
    ST_IDLE   = 7'b0000001,
    ST_SCAN   = 7'b0000010,
    ST_COMMIT = 7'b0000100,
    ST_EVAL   = 7'b0001000,
    ST_MOD    = 7'b0010000,
    ST_WALK   = 7'b0100000,
    ST_FINISH = 7'b1000000
  } state_e;

  state_e state_q, state_d;

  logic [1:0][PAT_W-1:0]   pattern_q, pattern_d;
  logic [1:0][CntW-1:0]    cnt_q, cnt_d;
  logic [1:0]              pzero_q, pzero_d;
  logic [1:0]              pone_q, pone_d;
  logic [1:0][SLOT_W-1:0]  period_q, period_d;
  logic [1:0][BLINK_W-1:0] blink_q, blink_d;
  logic [1:0]              flags_q, flags_d;
  logic [1:0][SLOT_W-1:0]  slot_q, slot_d;
  logic [DELAY_W-1:0]      delay_q, delay_d;
  logic [HOLD_W-1:0]       hold_q, hold_d;
  logic [1:0]              pins_q, pins_d;
  logic                    pause_q, pause_d;
  logic                    plevel_q, plevel_d;
  logic [HOLD_W-1:0]       holdcfg_q, holdcfg_d;
  logic                    out_valid_q, out_valid_d;
  logic [IdxW-1:0]         idx_q, idx_d;

  dlps_in_t                req_q, req_d;
  dlps_out_t               out_q, out_d;
  logic [1:0][PAT_W-1:0]   newpat_q, newpat_d;
  logic                    diff_q, diff_d;
  logic [1:0][SLOT_W-1:0]  sum_q, sum_d;
  logic [1:0]              hi_q, hi_d;
  logic [1:0]              nz_q, nz_d;
  logic [1:0][CntW-1:0]    top_q, top_d;
  logic [1:0][SLOT_W-1:0]  div_rem_q, div_rem_d;
  logic [1:0][SLOT_W-1:0]  div_sr_q, div_sr_d;
  logic [1:0][SLOT_W-1:0]  div_d_q, div_d_d;
  kind_e                   kind_q [2];
  kind_e                   kind_d [2];
  logic [1:0][PAT_W-1:0]   w_sr_q, w_sr_d;
  logic [1:0][CntW-1:0]    w_k_q, w_k_d;
  logic [1:0][CntW-1:0]    w_cnt_q, w_cnt_d;
  logic [1:0][SLOT_W-1:0]  w_next_q, w_next_d;
  logic [1:0]              w_phase_q, w_phase_d;
  logic [1:0]              w_done_q, w_done_d;
  logic [1:0]              w_lit_q, w_lit_d;

  logic                    restart;
  logic [1:0]              newb;
  logic [1:0]              ended;
  logic [1:0]              pins_n;
  logic [HOLD_W-1:0]       hold_n;
  logic [1:0][SLOT_W-1:0]  per;
  logic [1:0][3:0]         nib_new;
  logic [1:0][3:0]         nib_old;
  logic [1:0][SLOT_W:0]    div_t;
  logic [1:0][CntW-1:0]    k_inc;
  logic [1:0][PAT_W-1:0]   w_src;

  assign in_stall_o  = (state_q != ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_q;

  always_comb begin
    state_d     = state_q;
    pattern_d   = pattern_q;
    cnt_d       = cnt_q;
    pzero_d     = pzero_q;
    pone_d      = pone_q;
    period_d    = period_q;
    blink_d     = blink_q;
    flags_d     = flags_q;
    slot_d      = slot_q;
    delay_d     = delay_q;
    hold_d      = hold_q;
    pins_d      = pins_q;
    pause_d     = pause_q;
    plevel_d    = plevel_q;
    holdcfg_d   = holdcfg_q;
    out_valid_d = out_valid_q & out_stall_i;
    idx_d       = idx_q;
    req_d       = req_q;
    out_d       = out_q;
    newpat_d    = newpat_q;
    diff_d      = diff_q;
    sum_d       = sum_q;
    hi_d        = hi_q;
    nz_d        = nz_q;
    top_d       = top_q;
    div_rem_d   = div_rem_q;
    div_sr_d    = div_sr_q;
    div_d_d     = div_d_q;
    kind_d      = kind_q;
    w_sr_d      = w_sr_q;
    w_k_d       = w_k_q;
    w_cnt_d     = w_cnt_q;
    w_next_d    = w_next_q;
    w_phase_d   = w_phase_q;
    w_done_d    = w_done_q;
    w_lit_d     = w_lit_q;
    restart     = 1'b0;
    newb        = {(blink_q[1] != '0), (blink_q[0] != '0)};
    ended       = flags_q & ~newb;
    pins_n      = pins_q & ~newb;
    hold_n      = hold_q;
    per         = period_q;
    k_inc       = '0;
    w_src       = '0;
    div_t       = '0;
    for (int p = 0; p < 2; p++) begin
      nib_new[p] = newpat_q[p][3:0];
      nib_old[p] = pattern_q[p][3:0];
    end

    if (cfg_we_i) begin
      holdcfg_d = cfg_wdata_i;
    end

    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          req_d   = in_word_i;
          state_d = ST_EVAL;
          unique case (in_word_i.opcode)
            OP_TICK: begin
              if (delay_q != '0) begin
                delay_d = delay_q - 1'b1;
                if (delay_q == DELAY_W'(1)) begin
                  restart = 1'b1;
                end
              end
              if (hold_q != '0) begin
                hold_d = hold_q - 1'b1;
                if (hold_q == HOLD_W'(1)) begin
                  pins_d  = '0;
                  restart = 1'b1;
                end
              end
              for (int p = 0; p < 2; p++) begin
                slot_d[p] = restart ? '0 : slot_q[p] + 1'b1;
              end
            end
            OP_PATTERN: begin
              newpat_d = {in_word_i.secondary_pattern, in_word_i.primary_pattern};
              idx_d    = '0;
              diff_d   = 1'b0;
              sum_d    = '0;
              hi_d     = '0;
              nz_d     = '0;
              top_d    = '0;
              state_d  = ST_SCAN;
            end
            OP_BLINKS: begin
              blink_d = {in_word_i.secondary_blinks, in_word_i.primary_blinks};
            end
            OP_STEADY: begin
              blink_d[0] = in_word_i.flag ? BLINK_STEADY : '0;
            end
            OP_PAUSE: begin
              pause_d = in_word_i.flag;
            end
            OP_DELAY: begin
              delay_d = in_word_i.delay_slots;
              if (in_word_i.delay_slots == '0) begin
                slot_d = '0;
              end
            end
            default: begin
            end
          endcase
        end
      end

      ST_SCAN: begin
        for (int p = 0; p < 2; p++) begin
          if (nib_new[p] != nib_old[p]) begin
            diff_d = 1'b1;
          end
          if ({1'b0, idx_q} < FieldsLim) begin
            sum_d[p] = sum_q[p] + {4'b0, nib_new[p]};
            if (nib_new[p] != '0) begin
              top_d[p] = {1'b0, idx_q} + 1'b1;
            end
          end
          if (idx_q == '0) begin
            hi_d[p] = hi_q[p] | (nib_new[p][3:1] != '0);
          end else begin
            hi_d[p] = hi_q[p] | (nib_new[p] != '0);
          end
          nz_d[p]      = nz_q[p] | (nib_new[p] != '0);
          newpat_d[p]  = {nib_new[p], newpat_q[p][PAT_W-1:4]};
          pattern_d[p] = {nib_old[p], pattern_q[p][PAT_W-1:4]};
        end
        idx_d = idx_q + 1'b1;
        if (idx_q == ScanLast) begin
          state_d = ST_COMMIT;
        end
      end

      ST_COMMIT: begin
        delay_d = '0;
        if (diff_q) begin
          blink_d   = '0;
          pattern_d = newpat_q;
          cnt_d     = top_q;
          slot_d    = '0;
          for (int p = 0; p < 2; p++) begin
            pzero_d[p] = ~nz_q[p];
            pone_d[p]  = nz_q[p] & ~hi_q[p];
            if (hi_q[p]) begin
              period_d[p] = sum_q[p];
            end
          end
        end
        state_d = ST_EVAL;
      end

      ST_EVAL: begin
        if (pause_q) begin
          w_done_d  = 2'b11;
          w_lit_d   = {1'b0, plevel_q};
          kind_d[0] = KIND_ZERO;
          kind_d[1] = KIND_ZERO;
          state_d   = ST_FINISH;
        end else begin
          if (pins_n == '0) begin
            hold_n = '0;
          end
          if (newb != flags_q) begin
            if ((ended != '0) && (holdcfg_q != '0)) begin
              pins_n = pins_n | ended;
              hold_n = holdcfg_q;
            end
            restart = 1'b1;
          end
          flags_d = newb;
          pins_d  = pins_n;
          hold_d  = hold_n;
          for (int p = 0; p < 2; p++) begin
            if (blink_q[p] == BLINK_STEADY) begin
              kind_d[p] = KIND_ONE;
              per[p]    = STEADY_PERIOD;
            end else if (newb[p]) begin
              kind_d[p] = KIND_BLINK;
              per[p]    = BLINK_PERIOD;
            end else if ((delay_q != '0) || pzero_q[p]) begin
              kind_d[p] = KIND_ZERO;
            end else if (pone_q[p]) begin
              kind_d[p] = KIND_ONE;
            end else begin
              kind_d[p] = KIND_PAT;
            end
            if (!newb[p] && pins_n[p]) begin
              kind_d[p] = KIND_ZERO;
            end
            div_d_d[p]   = (per[p] == '0) ? SLOT_W'(1) : per[p];
            div_sr_d[p]  = restart ? '0 : slot_q[p];
            div_rem_d[p] = '0;
          end
          if (newb == 2'b01) begin
            kind_d[1] = KIND_ZERO;
          end else if (newb == 2'b10) begin
            kind_d[0] = KIND_ZERO;
          end
          idx_d   = '0;
          state_d = ST_MOD;
        end
      end

      ST_MOD: begin
        for (int p = 0; p < 2; p++) begin
          div_t[p] = {div_rem_q[p], div_sr_q[p][SLOT_W-1]};
          if (div_t[p] >= {1'b0, div_d_q[p]}) begin
            div_t[p] = div_t[p] - {1'b0, div_d_q[p]};
          end
          div_rem_d[p] = div_t[p][SLOT_W-1:0];
          div_sr_d[p]  = {div_sr_q[p][SLOT_W-2:0], 1'b0};
          w_src[p]     = (kind_q[p] == KIND_BLINK) ? BLINK_MASK : pattern_q[p];
        end
        idx_d = idx_q + 1'b1;
        if (idx_q == DivLast) begin
          for (int p = 0; p < 2; p++) begin
            slot_d[p]    = div_t[p][SLOT_W-1:0];
            w_sr_d[p]    = w_src[p];
            w_cnt_d[p]   = (kind_q[p] == KIND_BLINK) ? CntW'(2) : cnt_q[p];
            w_next_d[p]  = {4'b0, w_src[p][3:0]};
            w_k_d[p]     = '0;
            w_phase_d[p] = 1'b0;
            w_done_d[p]  = (kind_q[p] == KIND_ZERO) || (kind_q[p] == KIND_ONE);
            w_lit_d[p]   = (kind_q[p] == KIND_ONE);
          end
          state_d = ST_WALK;
        end
      end

      ST_WALK: begin
        for (int p = 0; p < 2; p++) begin
          k_inc[p] = w_k_q[p] + 1'b1;
          if (!w_done_q[p]) begin
            if (w_next_q[p] <= slot_q[p]) begin
              if (k_inc[p] >= w_cnt_q[p]) begin
                w_done_d[p] = 1'b1;
                w_lit_d[p]  = 1'b0;
              end else begin
                w_sr_d[p]    = {4'b0, w_sr_q[p][PAT_W-1:4]};
                w_next_d[p]  = w_next_q[p] + {4'b0, w_sr_q[p][7:4]};
                w_phase_d[p] = ~w_phase_q[p];
                w_k_d[p]     = k_inc[p];
              end
            end else begin
              w_done_d[p] = 1'b1;
              w_lit_d[p]  = ~w_phase_q[p];
            end
          end
        end
        if (w_done_q == 2'b11) begin
          state_d = ST_FINISH;
        end
      end

      ST_FINISH: begin
        if (!out_valid_q || !out_stall_i) begin
          out_d.primary_on   = w_lit_q[0];
          out_d.secondary_on = w_lit_q[1];
          out_d.delaying     = (delay_q != '0);
          out_d.paused_now   = pause_q;
          out_valid_d        = 1'b1;
          plevel_d           = w_lit_q[0];
          for (int p = 0; p < 2; p++) begin
            if ((req_q.opcode == OP_TICK) && !w_lit_q[p] &&
                ((kind_q[p] == KIND_PAT) || (kind_q[p] == KIND_BLINK)) &&
                (blink_q[p] != '0) && (blink_q[p] != BLINK_STEADY)) begin
              blink_d[p] = blink_q[p] - 1'b1;
            end
          end
          state_d = ST_IDLE;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      pattern_q   <= '0;
      cnt_q       <= '0;
      pzero_q     <= 2'b11;
      pone_q      <= '0;
      period_q    <= '0;
      blink_q     <= '0;
      flags_q     <= '0;
      slot_q      <= '0;
      delay_q     <= '0;
      hold_q      <= '0;
      pins_q      <= '0;
      pause_q     <= 1'b0;
      plevel_q    <= 1'b1;
      holdcfg_q   <= HOLD_RESET;
      out_valid_q <= 1'b0;
      idx_q       <= '0;
      w_done_q    <= '0;
    end else begin
      state_q     <= state_d;
      pattern_q   <= pattern_d;
      cnt_q       <= cnt_d;
      pzero_q     <= pzero_d;
      pone_q      <= pone_d;
      period_q    <= period_d;
      blink_q     <= blink_d;
      flags_q     <= flags_d;
      slot_q      <= slot_d;
      delay_q     <= delay_d;
      hold_q      <= hold_d;
      pins_q      <= pins_d;
      pause_q     <= pause_d;
      plevel_q    <= plevel_d;
      holdcfg_q   <= holdcfg_d;
      out_valid_q <= out_valid_d;
      idx_q       <= idx_d;
      w_done_q    <= w_done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    req_q     <= req_d;
    out_q     <= out_d;
    newpat_q  <= newpat_d;
    diff_q    <= diff_d;
    sum_q     <= sum_d;
    hi_q      <= hi_d;
    nz_q      <= nz_d;
    top_q     <= top_d;
    div_rem_q <= div_rem_d;
    div_sr_q  <= div_sr_d;
    div_d_q   <= div_d_d;
    kind_q    <= kind_d;
    w_sr_q    <= w_sr_d;
    w_k_q     <= w_k_d;
    w_cnt_q   <= w_cnt_d;
    w_next_q  <= w_next_d;
    w_phase_q <= w_phase_d;
    w_lit_q   <= w_lit_d;
  end

endmodule
